[hw/rtl/numeric_literal_validator_core_defines.svh]
// Assertion macros shared by the numeric literal validator RTL
`ifndef NUMERIC_LITERAL_VALIDATOR_CORE_DEFINES_SVH
`define NUMERIC_LITERAL_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define NLV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define NLV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/nlv_pkg.sv]
// Types, codes and character helpers for the numeric literal validator
`default_nettype none

package nlv_pkg;

	// value_class codes
	localparam logic [1:0] CLASS_ANY = 2'd0;
	localparam logic [1:0] CLASS_INT = 2'd1;
	localparam logic [1:0] CLASS_FLT = 2'd2;

	// register word index of value_class
	localparam logic REG_VALUE_CLASS = 1'b0;

	// characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	// parse phase
	typedef enum logic [3:0] {
		PH_START    = 4'd0,
		PH_ZERO     = 4'd1,
		PH_HEX_PFX  = 4'd2,
		PH_HEX_DIG  = 4'd3,
		PH_SIGN     = 4'd4,
		PH_DEC_DIG  = 4'd5,
		PH_TRAIL    = 4'd6,
		PH_F_SIGN   = 4'd7,
		PH_F_INT    = 4'd8,
		PH_F_DOT    = 4'd9,
		PH_F_FRAC   = 4'd10,
		PH_EXP      = 4'd11,
		PH_EXP_SIGN = 4'd12,
		PH_EXP_DIG  = 4'd13,
		PH_BAD      = 4'd15
	} phase_t;

	// control from the item path to the parser
	typedef struct packed {
		logic fire;     // an item is consumed this cycle
		logic restart;  // register write: begin a fresh string
	} step_ctl_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {8'd32, [8'd9:8'd13]};
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return c inside {[8'd48:8'd57]};
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'd48:8'd57], [8'd65:8'd70], [8'd97:8'd102]};
	endfunction

	function automatic logic is_sgn(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	// float: after a digit run (integer part, fraction or exponent)
	function automatic phase_t flt_after(input logic [7:0] c, input phase_t stay,
			input logic dot_ok);
		phase_t nx;
		if (is_dig(c)) begin
			nx = stay;
		end else if (dot_ok && c == CH_DOT) begin
			nx = PH_F_FRAC;
		end else if (stay != PH_EXP_DIG && (c == CH_LO_E || c == CH_UP_E)) begin
			nx = PH_EXP;
		end else if (c == CH_LO_F || c == CH_UP_F || is_ws(c)) begin
			nx = PH_TRAIL;
		end else begin
			nx = PH_BAD;
		end
		return nx;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/nlv_parser.sv]
// Parse state machine: phase and error registers plus the end-of-string verdict
`default_nettype none

module nlv_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nlv_pkg::step_ctl_t ctl,
	input  wire logic [7:0]        char_code,
	input  wire logic [1:0]        value_class,
	output logic                   verdict
);
	import nlv_pkg::*;

	phase_t phase_q, phase_d, nx;
	logic   err_q, err_d;
	logic   rules;
	logic   accepting;

	assign rules = (value_class == CLASS_INT) || (value_class == CLASS_FLT);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			err_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			err_q   <= err_d;
		end
	end

	// next phase per class
	always_comb begin
		nx = PH_BAD;
		if (value_class == CLASS_INT) begin
			case (phase_q)
				PH_START: begin
					if (is_ws(char_code))              nx = PH_START;
					else if (char_code == CH_ZERO)     nx = PH_ZERO;
					else if (is_dig(char_code))        nx = PH_DEC_DIG;
					else if (is_sgn(char_code))        nx = PH_SIGN;
				end
				PH_ZERO: begin
					if (char_code == CH_LO_X || char_code == CH_UP_X) nx = PH_HEX_PFX;
					else if (is_dig(char_code))        nx = PH_DEC_DIG;
					else if (is_ws(char_code))         nx = PH_TRAIL;
				end
				PH_HEX_PFX: begin
					if (is_hex(char_code))             nx = PH_HEX_DIG;
				end
				PH_HEX_DIG: begin
					if (is_hex(char_code))             nx = PH_HEX_DIG;
					else if (is_ws(char_code))         nx = PH_TRAIL;
				end
				PH_SIGN: begin
					if (is_dig(char_code))             nx = PH_DEC_DIG;
				end
				PH_DEC_DIG: begin
					if (is_dig(char_code))             nx = PH_DEC_DIG;
					else if (is_ws(char_code))         nx = PH_TRAIL;
				end
				PH_TRAIL: begin
					if (is_ws(char_code))              nx = PH_TRAIL;
				end
				default: nx = PH_BAD;
			endcase
		end else begin
			case (phase_q)
				PH_START: begin
					if (is_ws(char_code))              nx = PH_START;
					else if (is_sgn(char_code))        nx = PH_F_SIGN;
					else if (is_dig(char_code))        nx = PH_F_INT;
					else if (char_code == CH_DOT)      nx = PH_F_DOT;
				end
				PH_F_SIGN: begin
					if (is_dig(char_code))             nx = PH_F_INT;
					else if (char_code == CH_DOT)      nx = PH_F_DOT;
				end
				PH_F_INT:  nx = flt_after(char_code, PH_F_INT, 1'b1);
				PH_F_DOT: begin
					if (is_dig(char_code))             nx = PH_F_FRAC;
				end
				PH_F_FRAC: nx = flt_after(char_code, PH_F_FRAC, 1'b0);
				PH_EXP: begin
					if (is_sgn(char_code))             nx = PH_EXP_SIGN;
					else if (is_dig(char_code))        nx = PH_EXP_DIG;
				end
				PH_EXP_SIGN: begin
					if (is_dig(char_code))             nx = PH_EXP_DIG;
				end
				PH_EXP_DIG: nx = flt_after(char_code, PH_EXP_DIG, 1'b0);
				PH_TRAIL: begin
					if (is_ws(char_code))              nx = PH_TRAIL;
				end
				default: nx = PH_BAD;
			endcase
		end
	end

	// state update: restart on register write or NUL, else step when checking
	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		if (ctl.restart) begin
			phase_d = PH_START;
			err_d   = 1'b0;
		end else if (ctl.fire) begin
			if (char_code == CH_NUL) begin
				phase_d = PH_START;
				err_d   = 1'b0;
			end else if (rules && !err_q) begin
				if (nx == PH_BAD) begin
					err_d = 1'b1;
				end else begin
					phase_d = nx;
				end
			end
		end
	end

	// accepting end phases per class
	always_comb begin
		if (value_class == CLASS_INT) begin
			accepting = (phase_q == PH_ZERO) || (phase_q == PH_HEX_DIG) ||
				(phase_q == PH_DEC_DIG) || (phase_q == PH_TRAIL);
		end else begin
			accepting = (phase_q == PH_F_INT) || (phase_q == PH_F_FRAC) ||
				(phase_q == PH_EXP_DIG) || (phase_q == PH_TRAIL);
		end
	end

	assign verdict = rules ? (!err_q && accepting) : 1'b1;

endmodule

`default_nettype wire

[hw/rtl/numeric_literal_validator_core.sv]
// Top level of the numeric literal validator: register port, item stages, assertions
//
//   channel   dir   handshake                  payload
//   char      in    char_valid / char_stall    char_code[7:0]
//   result    out   result_valid / result_stall is_valid
//   config    in    APB psel/penable/pwrite    paddr[2:0], pwdata[31:0]
//
// One character per cycle while no NUL waits: it is captured in the input register,
// and the parse state machine consumes it from there; a NUL also loads the result
// register. Reset clears the class to 0 and the parser to the start of a string.
// A stalled result holds back only NULs, and the characters behind a waiting NUL;
// other characters keep flowing while a result waits.
`default_nettype none

module numeric_literal_validator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// character stream
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic [7:0]  char_code,
	// verdict stream
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             is_valid,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import nlv_pkg::*;

	logic [1:0] class_q;
	logic       cfg_wr;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       adv_s1;
	logic       load_s1;
	logic       verdict;
	logic       is_valid_q;
	logic       result_valid_q;
	step_ctl_t  ctl;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VALUE_CLASS);
	assign prdata = (paddr[2] == REG_VALUE_CLASS) ? {30'd0, class_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= CLASS_ANY;
		end else if (cfg_wr) begin
			class_q <= pwdata[1:0];
		end
	end

	// input stage: a NUL waits here while the result register is full and stalled
	assign adv_s1     = valid_s1 && ((char_s1 != CH_NUL) || !result_valid_q || !result_stall);
	assign char_stall = valid_s1 && !adv_s1;
	assign load_s1    = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			char_s1 <= char_code;
		end
	end

	// parser
	assign ctl.fire    = adv_s1;
	assign ctl.restart = cfg_wr;

	nlv_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.char_code   (char_s1),
		.value_class (class_q),
		.verdict     (verdict)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1 && char_s1 == CH_NUL) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && char_s1 == CH_NUL) begin
			is_valid_q <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign is_valid     = is_valid_q;

	// checks
`include "numeric_literal_validator_core_defines.svh"

	`NLV_ASSERT_NEXT(a_nul_makes_result, adv_s1 && char_s1 == CH_NUL, result_valid_q, "NUL consumed without a result")
	`NLV_ASSERT_NEXT(a_any_class_passes, adv_s1 && char_s1 == CH_NUL && class_q == CLASS_ANY, is_valid_q, "accept-any class gave an invalid result")
	`NLV_ASSERT_NOW(a_stall_only_on_nul, char_stall, valid_s1 && char_s1 == CH_NUL && result_valid_q, "input stalled without a waiting NUL")

endmodule

`default_nettype wire
